// ===== rtl/core/downmix_linear_resampler_macros.svh =====
// assertion macros shared by the resampler modules
`ifndef DOWNMIX_LINEAR_RESAMPLER_MACROS_SVH
`define DOWNMIX_LINEAR_RESAMPLER_MACROS_SVH

// same-cycle implication, disabled in reset
`define DLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dlr_pkg.sv =====
// shared constants and control types for the downmix linear resampler
package dlr_pkg;

  localparam int DATA_W          = 16;
  localparam int RATE_W          = 16;
  localparam int MAX_OUT         = 6;
  localparam int OUTPUT_RATE_DEF = 44100;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int RESET_RATE      = 44100;

  typedef struct packed {
    logic cap;
    logic pass_load;
    logic mul;
    logic last;
    logic emit;
    logic skip;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_ge_one;
    logic next_ge_one;
    logic slot_free;
    logic last_pend;
  } dp_stat_t;

endpackage

// ===== rtl/core/dlr_ifs.sv =====
// valid/ready channel interfaces for the input and result items
interface dlr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dlr_pkg::DATA_W-1:0] left_sample;
  logic signed [dlr_pkg::DATA_W-1:0] right_sample;
  logic                              is_stereo;

  modport source (output valid, left_sample, right_sample, is_stereo, input ready);
  modport sink (input valid, left_sample, right_sample, is_stereo, output ready);
endinterface

interface dlr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dlr_pkg::DATA_W-1:0] out_sample;
  logic                              last;

  modport source (output valid, out_sample, last, input ready);
  modport sink (input valid, out_sample, last, output ready);
endinterface

// ===== rtl/core/dlr_step_div.sv =====
// source rate register and reciprocal multiply for the phase step
`include "downmix_linear_resampler_macros.svh"

module dlr_step_div #(
  parameter int OUTPUT_RATE = dlr_pkg::OUTPUT_RATE_DEF,
  parameter int FRAC_BITS   = dlr_pkg::FRAC_BITS_DEF,
  parameter int STEP_W      = dlr_pkg::FRAC_BITS_DEF + 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [dlr_pkg::RATE_W-1:0] cfg_wr_data,
  output logic                       busy,
  output logic [STEP_W-1:0]          step,
  output logic                       passthrough
);

  // reciprocal of the output rate, scaled so that every 16-bit rate divides exactly
  localparam int RECIP_SH = dlr_pkg::RATE_W + $clog2(OUTPUT_RATE);
  localparam longint unsigned RECIP =
    ((64'd1 << (FRAC_BITS + RECIP_SH)) + 64'(OUTPUT_RATE) - 64'd1) / 64'(OUTPUT_RATE);
  localparam int RECIP_W = FRAC_BITS + RECIP_SH - $clog2(OUTPUT_RATE) + 2;
  localparam int PROD_W  = dlr_pkg::RATE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [dlr_pkg::RATE_W-1:0] rate_r;
  logic                       busy_r;
  logic [STEP_W-1:0]          step_r;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quo;
  logic [STEP_W-1:0] step_nxt;

  always_comb begin
    prod     = {{RECIP_W{1'b0}}, rate_r} * {{dlr_pkg::RATE_W{1'b0}}, RECIP_C};
    quo      = prod >> RECIP_SH;
    // a step that rounds to nothing still moves the phase
    step_nxt = (quo == '0) ? STEP_W'(1) : STEP_W'(quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      rate_r <= dlr_pkg::RATE_W'(dlr_pkg::RESET_RATE);
      step_r <= STEP_W'(1);
    end else if (cfg_wr_en) begin
      busy_r <= 1'b1;
      rate_r <= cfg_wr_data;
    end else if (busy_r) begin
      busy_r <= 1'b0;
      step_r <= step_nxt;
    end
  end

  assign busy        = busy_r;
  assign step        = step_r;
  assign passthrough = (rate_r == '0) || (32'(rate_r) == 32'(OUTPUT_RATE));

  `DLR_ASSERT_NOW(a_step_nonzero, !busy_r, step_r != '0, "phase step is zero after division")

endmodule

// ===== rtl/core/dlr_datapath.sv =====
// downmix, phase accumulator, interpolation multiplier and output register
module dlr_datapath #(
  parameter int FRAC_BITS = dlr_pkg::FRAC_BITS_DEF,
  parameter int STEP_W    = dlr_pkg::FRAC_BITS_DEF + 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dlr_pkg::dp_cmd_t                  cmd,
  input  logic [STEP_W-1:0]                 step,
  input  logic signed [dlr_pkg::DATA_W-1:0] left_sample,
  input  logic signed [dlr_pkg::DATA_W-1:0] right_sample,
  input  logic                              is_stereo,
  output dlr_pkg::dp_stat_t                 stat,
  dlr_out_if.source                         out_if
);

  localparam int DW     = dlr_pkg::DATA_W;
  localparam int PH_W   = STEP_W + 1;
  localparam int PROD_W = DW + FRAC_BITS + 2;
  localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRAC_BITS;

  logic signed [DW-1:0]     cur_r;
  logic signed [DW-1:0]     prev_r;
  logic [PH_W-1:0]          phase_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     last_pend_r;
  logic                     out_valid_r;
  logic [DW-1:0]            out_sample_r;
  logic                     out_last_r;

  logic signed [DW:0]        sum;
  logic signed [DW:0]        sum_adj;
  logic signed [DW:0]        half;
  logic signed [DW-1:0]      mono;
  logic [PH_W-1:0]           phase_sum;
  logic signed [DW:0]        diff;
  logic signed [FRAC_BITS:0] frac;
  logic signed [PROD_W-1:0]  prod_sh;
  logic [DW-1:0]             interp;

  always_comb begin
    sum     = {left_sample[DW-1], left_sample} + {right_sample[DW-1], right_sample};
    // round toward zero: odd negative sums move up by one before the halving
    sum_adj = sum + {{DW{1'b0}}, sum[DW] & sum[0]};
    half    = sum_adj >>> 1;
    mono    = is_stereo ? half[DW-1:0] : left_sample;

    phase_sum = phase_r + PH_W'(step);
    diff      = {cur_r[DW-1], cur_r} - {prev_r[DW-1], prev_r};
    frac      = {1'b0, phase_r[FRAC_BITS-1:0]};
    prod_sh   = prod_r >>> FRAC_BITS;
    interp    = prev_r + prod_sh[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul || cmd.skip) begin
        phase_r <= phase_sum;
      end else if (cmd.fin) begin
        phase_r <= phase_r - ONE;
      end
      if (cmd.fin || cmd.pass_load) begin
        prev_r <= cur_r;
      end
      if (cmd.emit || cmd.pass_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur_r <= mono;
    end
    if (cmd.mul) begin
      prod_r      <= diff * frac;
      last_pend_r <= cmd.last;
    end
    if (cmd.pass_load) begin
      out_sample_r <= cur_r;
      out_last_r   <= 1'b1;
    end else if (cmd.emit) begin
      out_sample_r <= interp;
      out_last_r   <= last_pend_r;
    end
  end

  always_comb begin
    stat.phase_ge_one = (phase_r >= ONE);
    stat.next_ge_one  = (phase_sum >= ONE);
    stat.slot_free    = !out_valid_r || out_if.ready;
    stat.last_pend    = last_pend_r;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_sample = out_sample_r;
  assign out_if.last       = out_last_r;

endmodule

// ===== rtl/core/dlr_ctrl.sv =====
// sequencing state machine: capture, product, emit and phase wrap per item, or capture and passthrough load
`include "downmix_linear_resampler_macros.svh"

module dlr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              step_busy,
  input  logic              passthrough,
  input  dlr_pkg::dp_stat_t stat,
  output dlr_pkg::dp_cmd_t  cmd
);

  localparam int CW = $clog2(dlr_pkg::MAX_OUT + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PASS = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]    state_r;
  logic [2:0]    state_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          in_acc;
  logic          cap_last;

  // result count reaching the limit also closes the burst
  assign cap_last = (cnt_r == CW'(dlr_pkg::MAX_OUT - 1)) || stat.next_ge_one;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !step_busy;
        if (in_valid && !step_busy) begin
          cmd.cap   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = passthrough ? ST_PASS : ST_MUL;
        end
      end
      ST_PASS: begin
        if (stat.slot_free) begin
          cmd.pass_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (stat.phase_ge_one) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.mul   = 1'b1;
          cmd.last  = cap_last;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.last_pend) begin
            state_nxt = ST_FIN;
          end else begin
            // next product overlaps the load of this result
            cmd.mul  = 1'b1;
            cmd.last = cap_last;
            cnt_nxt  = cnt_r + CW'(1);
          end
        end
      end
      ST_FIN: begin
        if (!stat.phase_ge_one) begin
          cmd.skip = 1'b1;
        end else begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `DLR_ASSERT_NOW(a_emit_count, state_r == ST_EMIT, (cnt_r != '0) && (cnt_r <= CW'(dlr_pkg::MAX_OUT)), "result count out of range while emitting")
  `DLR_ASSERT_NEXT(a_pass_route, in_acc && passthrough, state_r == ST_PASS, "passthrough item not routed to pass state")
  `DLR_ASSERT_NEXT(a_last_closes, (state_r == ST_EMIT) && stat.slot_free && stat.last_pend, state_r == ST_FIN, "last result did not close the burst")

endmodule

// ===== rtl/core/downmix_linear_resampler.sv =====
// per item: capture, product, then each result loads the output register when the slot is free,
// overlapped with the next product, and a phase wrap; a new item is taken only back in idle
// an item past six results walks the phase over the skipped steps; passthrough is capture and load
// the phase step comes from a reciprocal multiply, registered after reset and every rate write
// in_ready stays low while it runs; reset gives rate 44100, phase and previous sample zero
module downmix_linear_resampler #(
  parameter int OUTPUT_RATE = dlr_pkg::OUTPUT_RATE_DEF,
  parameter int FRAC_BITS   = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  dlr_in_if.sink                     in_if,
  dlr_out_if.source                  out_if,
  input  logic                       cfg_wr_en,
  input  logic [dlr_pkg::RATE_W-1:0] cfg_wr_data
);

  localparam int STEP_W = FRAC_BITS + 4;

  logic              step_busy;
  logic [STEP_W-1:0] step;
  logic              passthrough;
  logic              in_ready;
  dlr_pkg::dp_cmd_t  cmd;
  dlr_pkg::dp_stat_t stat;

  assign in_if.ready = in_ready;

  dlr_step_div #(
    .OUTPUT_RATE (OUTPUT_RATE),
    .FRAC_BITS   (FRAC_BITS),
    .STEP_W      (STEP_W)
  ) u_step_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .busy        (step_busy),
    .step        (step),
    .passthrough (passthrough)
  );

  dlr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_ready),
    .step_busy   (step_busy),
    .passthrough (passthrough),
    .stat        (stat),
    .cmd         (cmd)
  );

  dlr_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .STEP_W    (STEP_W)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .step         (step),
    .left_sample  (in_if.left_sample),
    .right_sample (in_if.right_sample),
    .is_stereo    (in_if.is_stereo),
    .stat         (stat),
    .out_if       (out_if)
  );

endmodule

// ===== dv/tb_downmix_linear_resampler.sv =====
`timescale 1ns / 100ps
// self-checking bench for the downmix linear resampler under bursty input, output stalls and rate changes
module tb_downmix_linear_resampler;

  localparam int W          = dlr_pkg::DATA_W;
  localparam int OUT_RATE   = dlr_pkg::OUTPUT_RATE_DEF;
  localparam int FRAC       = dlr_pkg::FRAC_BITS_DEF;
  localparam int PHASE_ONE  = 1 << FRAC;
  localparam int SETTLE_CYC = 16;

  typedef struct packed {
    logic signed [W-1:0] left;
    logic signed [W-1:0] right;
    logic                stereo;
  } pcm_in_t;

  typedef struct packed {
    logic signed [W-1:0] sample;
    logic                last;
  } pcm_out_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [dlr_pkg::RATE_W-1:0] cfg_wr_data;

  dlr_in_if  pcm_in ();
  dlr_out_if pcm_out ();

  downmix_linear_resampler u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (pcm_in),
    .out_if      (pcm_out),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pcm_in_t  pend_q[$];
  pcm_out_t pcm_expected[$];
  int       err_count = 0;

  // mirror of the resampler state
  logic [15:0]          rate_hz;
  logic [17:0]          phase_pos;
  logic signed [W-1:0]  prev_mono;
  logic [16:0]          phase_inc;
  int unsigned          last_skip = 0;

  bit          tx_on = 1'b0;
  bit          tx_calm = 1'b0;
  int unsigned tx_count = 0;
  bit          rx_on = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned rx_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[downmix_linear_resampler] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void set_rate(input logic [15:0] r);
    logic [31:0] q;
    q = {r, 16'h0000} / OUT_RATE;
    rate_hz = r;
    phase_inc = (q == 0) ? 17'd1 : q[16:0];
  endfunction

  function automatic void interpolate_item(input pcm_in_t it);
    int       cur;
    int       n;
    longint   diff;
    longint   val;
    pcm_out_t res;
    cur = it.stereo ? (int'(it.left) + int'(it.right)) / 2 : int'(it.left);
    last_skip = 0;
    if (rate_hz == 0 || rate_hz == OUT_RATE) begin
      res.sample = cur[W-1:0];
      res.last = 1'b1;
      pcm_expected.push_back(res);
      prev_mono = cur[W-1:0];
      return;
    end
    n = 0;
    while (phase_pos < PHASE_ONE && n < dlr_pkg::MAX_OUT) begin
      diff = longint'(cur) - longint'(prev_mono);
      val = longint'(prev_mono) + ((diff * longint'(phase_pos[FRAC-1:0])) >>> FRAC);
      res.sample = val[W-1:0];
      res.last = (phase_pos + phase_inc >= PHASE_ONE) || (n == dlr_pkg::MAX_OUT - 1);
      pcm_expected.push_back(res);
      n++;
      phase_pos = phase_pos + phase_inc;
    end
    // outputs past the cap are dropped but the phase still walks over them
    while (phase_pos < PHASE_ONE) begin
      phase_pos = phase_pos + phase_inc;
      last_skip++;
    end
    phase_pos = phase_pos - PHASE_ONE;
    prev_mono = cur[W-1:0];
  endfunction

  function automatic void push_pcm(input int l, input int r, input bit st);
    pcm_in_t it;
    it.left = l[W-1:0];
    it.right = r[W-1:0];
    it.stereo = st;
    pend_q.push_back(it);
  endfunction

  function automatic void push_random_pcm();
    int l;
    int r;
    case ($urandom_range(0, 9))
      6, 7: begin
        l = int'($urandom_range(0, 400)) - 200;
        r = int'($urandom_range(0, 400)) - 200;
      end
      8, 9: begin
        l = $urandom_range(0, 1) ? 32767 : -32768;
        r = $urandom_range(0, 1) ? 32767 : -32768;
      end
      default: begin
        l = $urandom;
        r = $urandom;
      end
    endcase
    push_pcm(l, r, 1'($urandom_range(0, 1)));
  endfunction

  // wait for every item to be taken and answered, then let any phase skipping finish
  task automatic drain();
    while (pend_q.size() != 0 || pcm_expected.size() != 0) @(posedge clk);
    repeat (last_skip + SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_rate(input logic [15:0] r);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    set_rate(r);
  endtask

  // sender: bursts of items with random gaps
  always @(posedge clk) begin : drive_blk
    pcm_in_t nxt;
    if (!rst_n) begin
      pcm_in.valid <= 1'b0;
    end else if (!(pcm_in.valid && !pcm_in.ready)) begin
      if (pcm_in.valid) interpolate_item(pend_q.pop_front());
      if (tx_count == 0) begin
        tx_on = !tx_on || tx_calm;
        tx_count = tx_on ? $urandom_range(1, 16) : $urandom_range(1, 5);
      end
      tx_count--;
      if (tx_on && pend_q.size() != 0) begin
        nxt = pend_q[0];
        pcm_in.valid <= 1'b1;
        pcm_in.left_sample <= nxt.left;
        pcm_in.right_sample <= nxt.right;
        pcm_in.is_stereo <= nxt.stereo;
      end else begin
        pcm_in.valid <= 1'b0;
      end
    end
  end

  // receiver: alternating ready and stall stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      pcm_out.ready <= 1'b0;
    end else begin
      if (rx_count == 0) begin
        rx_on = !rx_on || rx_calm;
        rx_count = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 3);
      end
      rx_count--;
      pcm_out.ready <= rx_on;
    end
  end

  always @(posedge clk) begin : check_blk
    pcm_out_t want;
    if (rst_n && pcm_out.valid && pcm_out.ready) begin
      if (pcm_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d last %0b with nothing expected",
                                  pcm_out.out_sample, pcm_out.last));
      end else begin
        want = pcm_expected.pop_front();
        if (pcm_out.out_sample !== want.sample)
          report_mismatch($sformatf("out_sample %0d, want %0d", pcm_out.out_sample, want.sample));
        if (pcm_out.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", pcm_out.last, want.last));
      end
    end
  end

  initial begin : stim_blk
    int unsigned rate_plan[10];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    pcm_in.valid = 1'b0;
    pcm_in.left_sample = '0;
    pcm_in.right_sample = '0;
    pcm_in.is_stereo = 1'b0;
    pcm_out.ready = 1'b0;
    set_rate(16'(dlr_pkg::RESET_RATE));
    phase_pos = '0;
    prev_mono = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset rate passes straight through: mix extremes and rounding toward zero
    push_pcm(32767, 32767, 1'b1);
    push_pcm(-32768, -32768, 1'b1);
    push_pcm(32767, -32768, 1'b1);
    push_pcm(-32768, 32767, 1'b1);
    push_pcm(-3, 0, 1'b1);
    push_pcm(3, 0, 1'b1);
    push_pcm(-32768, 1234, 1'b0);
    push_pcm(32767, -1, 1'b0);
    drain();

    // rate zero behaves as passthrough
    write_rate(16'd0);
    push_pcm(-5, 9, 1'b1);
    push_pcm(100, -100, 1'b0);
    drain();

    // slowest nominal rate, full-scale swings
    write_rate(16'd8000);
    push_pcm(-32768, 0, 1'b0);
    push_pcm(32767, 0, 1'b0);
    push_pcm(-32768, 0, 1'b0);
    push_pcm(0, -32768, 1'b1);
    drain();

    // smallest step: output cap hit and a long skip
    write_rate(16'd1);
    push_pcm(32767, 32767, 1'b1);
    push_pcm(-32768, 0, 1'b0);
    drain();

    // fastest rate: downsampling, some items give nothing
    write_rate(16'hFFFF);
    push_pcm(1000, 2000, 1'b1);
    push_pcm(-1000, 7, 1'b0);
    push_pcm(32767, 32767, 1'b0);
    push_pcm(-32768, -32768, 1'b1);
    drain();

    rate_plan = '{8000, 48000, 7000, 44100, 22050, 65535, 0, 11025, 0, 0};
    rate_plan[8] = $urandom_range(8000, 48000);
    rate_plan[9] = $urandom_range(2000, 65535);
    for (int p = 0; p < 10; p++) begin
      write_rate(rate_plan[p][15:0]);
      tx_calm = (p % 4 == 2);
      rx_calm = (p % 3 == 1);
      repeat (11) push_random_pcm();
      drain();
    end

    if (err_count == 0) begin
      $display("[downmix_linear_resampler] OK");
    end else begin
      $display("[downmix_linear_resampler] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dlr_pkg.sv
rtl/core/dlr_ifs.sv
rtl/core/dlr_step_div.sv
rtl/core/dlr_datapath.sv
rtl/core/dlr_ctrl.sv
rtl/core/downmix_linear_resampler.sv
dv/tb_downmix_linear_resampler.sv
